[design/video_stream_rate_shaper_assert.svh]
// assertion macros shared by the rate shaper modules
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef VIDEO_STREAM_RATE_SHAPER_ASSERT_SVH
`define VIDEO_STREAM_RATE_SHAPER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// plain property check, disabled while reset is high
`define VSRS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rate shaper check failed");
// antecedent in this cycle implies consequent in the next one
`define VSRS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rate shaper sequence check failed");
`else
`define VSRS_ASSERT(name, clk, rst, prop)
`define VSRS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

[design/vsrs_pkg.sv]
// shared types and constants of the video stream rate shaper
// used by vsrs_csr, vsrs_alu and video_stream_rate_shaper
`timescale 1ns / 1ps

package vsrs_pkg;

   // fixed field widths
   localparam int BYTE_BITS      = 48;
   localparam int NOW_BITS       = 48;
   localparam int SIZE_BITS      = 16;
   localparam int RATE_BITS      = 10;
   localparam int FRAME_CNT_BITS = 16;
   localparam int ALLOW_BITS     = 40;
   localparam int IVAL_BITS      = 30;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 40;

   // shared unit: one operand bit per step
   localparam int OPA_BITS  = 48;
   localparam int STEP_BITS = $clog2(OPA_BITS);

   localparam logic [BYTE_BITS-1:0]      BYTE_MAX      = '1;
   localparam logic [FRAME_CNT_BITS-1:0] FRAME_CNT_MAX = '1;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_OVER  = 2'd1;
   localparam logic [1:0] STATUS_DELAY = 2'd2;
   localparam logic [1:0] STATUS_NA    = 2'd3;

   // word kinds
   localparam logic KIND_PACKET = 1'b0;
   localparam logic KIND_FRAME  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_ENABLE           = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_RATE       = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_BYTES      = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_QUANTUM_BYTES    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_INTERVAL   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_QUANTUM_INTERVAL = 3'd5;

   // configuration seen by the datapath
   typedef struct packed {
      logic                  clear;
      logic                  enable;
      logic [RATE_BITS-1:0]  frame_rate;
      logic [ALLOW_BITS-1:0] frame_bytes;
      logic [ALLOW_BITS-1:0] quantum_bytes;
      logic [IVAL_BITS-1:0]  frame_interval;
      logic [IVAL_BITS-1:0]  quantum_interval;
   } cfg_type;

   // shared unit command and status
   typedef struct packed {
      logic start;
      logic is_div;
   } alu_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_sts_type;

endpackage

[design/video_stream_rate_shaper.sv]
// video stream rate shaper: sequencer, shaping state and result register
// depends on vsrs_pkg, vsrs_csr, vsrs_alu and the assertion header
`timescale 1ns / 1ps
`include "video_stream_rate_shaper_assert.svh"

// Usage
//   req_*: one word per packet (req_kind 0, req_size bytes) or frame boundary
//   (req_kind 1), each with the current time req_now_ns. rsp_*: one result
//   word per request word, in order: status, wait until next refill, frames
//   left in the window. csr_*: register writes, only while the block is idle.
// Timing
//   A word is taken when req_valid is high and req_stall low; req_stall then
//   stays high until the result sits in the output register.
//   A plain packet goes through PREP, CHECK and DONE; a disabled word or a
//   window close goes through PREP and DONE. Refills due (interval not zero):
//   a 48-step divide and a 48-step multiply on the shared unit, then CHECK.
//   A frame boundary runs one multiply in NEED and MUL2, plus a divide and a
//   multiply first when frame slots have gone by (interval not zero).
//   The shared unit works on one operand bit per cycle.
// Reset and stall
//   Synchronous reset clears control registers and shaping state; no clearing pass.
//   A stalled result holds in the output register; the next request word is
//   still taken and worked on, and waits only if it finishes before the
//   earlier result has gone.

module video_stream_rate_shaper #(
   parameter int          TIME_BITS = 48,
   parameter int unsigned WINDOW_NS = 1000000000
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic [vsrs_pkg::NOW_BITS-1:0]        req_now_ns,
   input  logic [vsrs_pkg::SIZE_BITS-1:0]       req_size,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [vsrs_pkg::NOW_BITS-1:0]        rsp_wait_ns,
   output logic [vsrs_pkg::RATE_BITS-1:0]       rsp_frames_left,
   // register port
   input  logic                                 csr_we,
   input  logic [vsrs_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [vsrs_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int TW = TIME_BITS;
   localparam int NW = (TIME_BITS > vsrs_pkg::NOW_BITS) ? TIME_BITS : vsrs_pkg::NOW_BITS;
   localparam logic [NW-1:0] TIME_MAX_NW = (NW'(1) << TW) - NW'(1);
   localparam int BB = vsrs_pkg::BYTE_BITS;
   localparam int FB = vsrs_pkg::FRAME_CNT_BITS;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_PREP  = 8'b0000_0010,
      ST_DIV   = 8'b0000_0100,
      ST_MUL1  = 8'b0000_1000,
      ST_NEED  = 8'b0001_0000,
      ST_MUL2  = 8'b0010_0000,
      ST_CHECK = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   function automatic logic [BB-1:0] sat_add_bytes(logic [BB-1:0] a, logic [BB-1:0] b);
      logic [BB:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[BB] ? vsrs_pkg::BYTE_MAX : s[BB-1:0];
   endfunction

   function automatic logic [FB-1:0] sat_add_cnt(logic [FB-1:0] a, logic [FB-1:0] b);
      logic [FB:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[FB] ? vsrs_pkg::FRAME_CNT_MAX : s[FB-1:0];
   endfunction

   function automatic logic [TW-1:0] sat_add_time(logic [TW-1:0] a, logic [TW-1:0] b);
      logic [TW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TW] ? {TW{1'b1}} : s[TW-1:0];
   endfunction

   vsrs_pkg::cfg_type      cfg;
   vsrs_pkg::alu_ctl_type  alu_ctl;
   vsrs_pkg::alu_sts_type  alu_sts;
   logic [vsrs_pkg::OPA_BITS-1:0] alu_opa;
   logic [NW-1:0]                 alu_opb;
   logic [NW-1:0]                 alu_lim;
   logic [vsrs_pkg::OPA_BITS-1:0] alu_quo;
   logic [NW-1:0]                 alu_acc;

   state_type                     state_ff, state_in;

   // captured request word
   logic                          kind_ff, kind_in;
   logic [TW-1:0]                 now_ff, now_in;
   logic [vsrs_pkg::SIZE_BITS-1:0] size_ff, size_in;

   // shaping state
   logic                          started_ff, started_in;
   logic [BB-1:0]                 bl_ff, bl_in;
   logic [BB-1:0]                 bs_ff, bs_in;
   logic [BB-1:0]                 cq_ff, cq_in;
   logic [vsrs_pkg::RATE_BITS-1:0] fr_ff, fr_in;
   logic [FB-1:0]                 fideal_ff, fideal_in;
   logic [FB-1:0]                 fa_ff, fa_in;
   logic [TW-1:0]                 we_ff, we_in;
   logic [TW-1:0]                 nft_ff, nft_in;
   logic [TW-1:0]                 nqt_ff, nqt_in;

   // pending result and output register
   logic [1:0]                    res_status_ff, res_status_in;
   logic [vsrs_pkg::NOW_BITS-1:0] res_wait_ff, res_wait_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    rsp_status_ff, rsp_status_in;
   logic [vsrs_pkg::NOW_BITS-1:0] rsp_wait_ff, rsp_wait_in;
   logic [vsrs_pkg::RATE_BITS-1:0] rsp_fl_ff, rsp_fl_in;

   // helpers
   logic [NW-1:0]                 req_now_nw;
   logic [TW-1:0]                 now_clamp;
   logic [NW-1:0]                 now_nw;
   logic                          nqt_lt_now;
   logic                          nft_lt_now;
   logic [NW-1:0]                 dq_nw;
   logic [NW-1:0]                 df_nw;
   logic [NW-1:0]                 wait_nw;
   logic [vsrs_pkg::NOW_BITS-1:0] wait_calc;
   logic [vsrs_pkg::OPA_BITS-1:0] quo_p1;
   logic [vsrs_pkg::RATE_BITS-1:0] n_frame;
   logic [NW:0]                   refill_sum;
   logic [TW-1:0]                 refill_time;
   logic [BB-1:0]                 want;
   logic [BB-1:0]                 need;

   vsrs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vsrs_alu #(
      .W (NW)
   ) u_alu (
      .clock (clock),
      .reset (reset),
      .ctl   (alu_ctl),
      .opa   (alu_opa),
      .opb   (alu_opb),
      .lim   (alu_lim),
      .sts   (alu_sts),
      .quo   (alu_quo),
      .acc   (alu_acc)
   );

   // time compares, elapsed spans and refill wait
   always_comb begin
      req_now_nw  = NW'(req_now_ns);
      now_clamp   = (req_now_nw > TIME_MAX_NW) ? {TW{1'b1}} : req_now_nw[TW-1:0];
      now_nw      = NW'(now_ff);
      nqt_lt_now  = nqt_ff < now_ff;
      nft_lt_now  = nft_ff < now_ff;
      dq_nw       = NW'(now_ff - nqt_ff - TW'(1));
      df_nw       = NW'(now_ff - nft_ff - TW'(1));
      wait_nw     = (nqt_ff > now_ff) ? NW'(nqt_ff - now_ff) : '0;
      wait_calc   = wait_nw[vsrs_pkg::NOW_BITS-1:0];
      quo_p1      = alu_quo + vsrs_pkg::OPA_BITS'(1);
      n_frame     = (quo_p1 < vsrs_pkg::OPA_BITS'(fr_ff)) ?
                    quo_p1[vsrs_pkg::RATE_BITS-1:0] : fr_ff;
      // last refill point plus one interval: now - 1 - rem + interval
      refill_sum  = {1'b0, now_nw} - (NW+1)'(1) + (NW+1)'(cfg.quantum_interval)
                    - {1'b0, alu_acc};
      refill_time = (refill_sum > {1'b0, TIME_MAX_NW}) ? {TW{1'b1}} : refill_sum[TW-1:0];
      want        = sat_add_bytes(bs_ff, BB'(size_ff));
      need        = alu_acc[BB-1:0];
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      now_in        = now_ff;
      size_in       = size_ff;
      started_in    = started_ff;
      bl_in         = bl_ff;
      bs_in         = bs_ff;
      cq_in         = cq_ff;
      fr_in         = fr_ff;
      fideal_in     = fideal_ff;
      fa_in         = fa_ff;
      we_in         = we_ff;
      nft_in        = nft_ff;
      nqt_in        = nqt_ff;
      res_status_in = res_status_ff;
      res_wait_in   = res_wait_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_fl_in     = rsp_fl_ff;
      alu_ctl       = '0;
      alu_opa       = '0;
      alu_opb       = '0;
      alu_lim       = '0;

      // output word taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               now_in   = now_clamp;
               size_in  = req_size;
               state_in = ST_PREP;
            end
         end

         ST_PREP: begin
            res_wait_in = '0;
            if (!cfg.enable) begin
               res_status_in = vsrs_pkg::STATUS_NA;
               state_in      = ST_DONE;
            end else if (kind_ff == vsrs_pkg::KIND_PACKET) begin
               if (!started_ff) begin
                  // first packet opens the window
                  started_in = 1'b1;
                  bl_in      = BB'(cfg.quantum_bytes);
                  bs_in      = '0;
                  cq_in      = BB'(cfg.quantum_bytes);
                  fr_in      = cfg.frame_rate;
                  fideal_in  = FB'(1);
                  fa_in      = FB'(1);
                  we_in      = sat_add_time(now_ff, TW'(WINDOW_NS));
                  nft_in     = sat_add_time(now_ff, TW'(cfg.frame_interval));
                  nqt_in     = sat_add_time(now_ff, TW'(cfg.quantum_interval));
                  state_in   = ST_CHECK;
               end else if (nqt_lt_now && cfg.quantum_interval == '0) begin
                  bl_in    = sat_add_bytes(bl_ff, cq_ff);
                  state_in = ST_CHECK;
               end else if (nqt_lt_now) begin
                  // count elapsed refills
                  alu_ctl.start  = 1'b1;
                  alu_ctl.is_div = 1'b1;
                  alu_opa        = dq_nw[vsrs_pkg::OPA_BITS-1:0];
                  alu_opb        = NW'(cfg.quantum_interval);
                  state_in       = ST_DIV;
               end else begin
                  state_in = ST_CHECK;
               end
            end else begin
               if (fr_ff == '0) begin
                  // window used up: close it
                  if (now_ff < we_ff) begin
                     res_status_in = vsrs_pkg::STATUS_OVER;
                     res_wait_in   = wait_calc;
                  end else begin
                     res_status_in = vsrs_pkg::STATUS_OK;
                  end
                  started_in = 1'b0;
                  bl_in      = '0;
                  bs_in      = '0;
                  cq_in      = '0;
                  fideal_in  = '0;
                  fa_in      = '0;
                  we_in      = '0;
                  nft_in     = '0;
                  nqt_in     = '0;
                  state_in   = ST_DONE;
               end else begin
                  fa_in = sat_add_cnt(fa_ff, FB'(1));
                  if (nft_lt_now && cfg.frame_interval != '0) begin
                     // count frame slots gone by
                     alu_ctl.start  = 1'b1;
                     alu_ctl.is_div = 1'b1;
                     alu_opa        = df_nw[vsrs_pkg::OPA_BITS-1:0];
                     alu_opb        = NW'(cfg.frame_interval);
                     state_in       = ST_DIV;
                  end else if (nft_lt_now) begin
                     fideal_in = sat_add_cnt(fideal_ff, FB'(fr_ff));
                     fr_in     = '0;
                     state_in  = ST_NEED;
                  end else begin
                     state_in = ST_NEED;
                  end
               end
            end
         end

         ST_DIV: begin
            if (alu_sts.done) begin
               alu_ctl.start = 1'b1;
               if (kind_ff == vsrs_pkg::KIND_PACKET) begin
                  // refill count times current quantum
                  nqt_in  = refill_time;
                  alu_opa = quo_p1;
                  alu_opb = NW'(cq_ff);
                  alu_lim = NW'(vsrs_pkg::BYTE_MAX);
               end else begin
                  // advance the ideal frame pace
                  fr_in     = fr_ff - n_frame;
                  fideal_in = sat_add_cnt(fideal_ff, FB'(n_frame));
                  alu_opa   = vsrs_pkg::OPA_BITS'(n_frame);
                  alu_opb   = NW'(cfg.frame_interval);
                  alu_lim   = TIME_MAX_NW;
               end
               state_in = ST_MUL1;
            end
         end

         ST_MUL1: begin
            if (alu_sts.done) begin
               if (kind_ff == vsrs_pkg::KIND_PACKET) begin
                  bl_in    = sat_add_bytes(bl_ff, alu_acc[BB-1:0]);
                  state_in = ST_CHECK;
               end else begin
                  nft_in   = sat_add_time(nft_ff, alu_acc[TW-1:0]);
                  state_in = ST_NEED;
               end
            end
         end

         ST_NEED: begin
            // bytes owed for the frames sent so far
            alu_ctl.start = 1'b1;
            alu_opa       = vsrs_pkg::OPA_BITS'(fa_ff);
            alu_opb       = NW'(cfg.frame_bytes);
            alu_lim       = NW'(vsrs_pkg::BYTE_MAX);
            state_in      = ST_MUL2;
         end

         ST_MUL2: begin
            if (alu_sts.done) begin
               if (bs_ff < need) begin
                  bs_in = need;
               end
               if (fideal_ff <= fa_ff) begin
                  cq_in         = BB'(cfg.quantum_bytes);
                  res_status_in = vsrs_pkg::STATUS_OK;
               end else begin
                  cq_in         = cq_ff[BB-1] ? vsrs_pkg::BYTE_MAX : {cq_ff[BB-2:0], 1'b0};
                  res_status_in = vsrs_pkg::STATUS_DELAY;
               end
               state_in = ST_DONE;
            end
         end

         ST_CHECK: begin
            // budget check for the packet
            if (bl_ff < want) begin
               res_status_in = vsrs_pkg::STATUS_OVER;
               res_wait_in   = wait_calc;
            end else begin
               bs_in         = want;
               res_status_in = vsrs_pkg::STATUS_OK;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_wait_in   = res_wait_ff;
               rsp_fl_in     = fr_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // reconfiguration clears the shaping state
      if (cfg.clear) begin
         started_in = 1'b0;
         bl_in      = '0;
         bs_in      = '0;
         cq_in      = '0;
         fr_in      = '0;
         fideal_in  = '0;
         fa_in      = '0;
         we_in      = '0;
         nft_in     = '0;
         nqt_in     = '0;
      end
   end

   // control and shaping state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         bl_ff        <= '0;
         bs_ff        <= '0;
         cq_ff        <= '0;
         fr_ff        <= '0;
         fideal_ff    <= '0;
         fa_ff        <= '0;
         we_ff        <= '0;
         nft_ff       <= '0;
         nqt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         bl_ff        <= bl_in;
         bs_ff        <= bs_in;
         cq_ff        <= cq_in;
         fr_ff        <= fr_in;
         fideal_ff    <= fideal_in;
         fa_ff        <= fa_in;
         we_ff        <= we_in;
         nft_ff       <= nft_in;
         nqt_ff       <= nqt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // word and result payload
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      now_ff        <= now_in;
      size_ff       <= size_in;
      res_status_ff <= res_status_in;
      res_wait_ff   <= res_wait_in;
      rsp_status_ff <= rsp_status_in;
      rsp_wait_ff   <= rsp_wait_in;
      rsp_fl_ff     <= rsp_fl_in;
   end

   assign req_stall       = state_ff != ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_wait_ns     = rsp_wait_ff;
   assign rsp_frames_left = rsp_fl_ff;

   // checks
   `VSRS_ASSERT_NEXT(a_accept_stalls, clock, reset, req_valid && !req_stall, req_stall)
   `VSRS_ASSERT(a_alu_done_state, clock, reset,
      alu_sts.done |-> (state_ff == ST_DIV || state_ff == ST_MUL1 || state_ff == ST_MUL2))
   `VSRS_ASSERT(a_frames_bounded, clock, reset, fr_ff <= cfg.frame_rate)
   `VSRS_ASSERT(a_na_no_wait, clock, reset,
      (rsp_valid_ff && rsp_status_ff == vsrs_pkg::STATUS_NA) |-> (rsp_wait_ff == '0))

endmodule

[design/vsrs_csr.sv]
// configuration registers of the rate shaper
// depends on vsrs_pkg; any valid write also requests a state clear
`timescale 1ns / 1ps

module vsrs_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [vsrs_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [vsrs_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output vsrs_pkg::cfg_type                    cfg
);

   logic                                enable_ff, enable_in;
   logic [vsrs_pkg::RATE_BITS-1:0]      frame_rate_ff, frame_rate_in;
   logic [vsrs_pkg::ALLOW_BITS-1:0]     frame_bytes_ff, frame_bytes_in;
   logic [vsrs_pkg::ALLOW_BITS-1:0]     quantum_bytes_ff, quantum_bytes_in;
   logic [vsrs_pkg::IVAL_BITS-1:0]      frame_ival_ff, frame_ival_in;
   logic [vsrs_pkg::IVAL_BITS-1:0]      quantum_ival_ff, quantum_ival_in;

   // register write decode
   always_comb begin
      enable_in        = enable_ff;
      frame_rate_in    = frame_rate_ff;
      frame_bytes_in   = frame_bytes_ff;
      quantum_bytes_in = quantum_bytes_ff;
      frame_ival_in    = frame_ival_ff;
      quantum_ival_in  = quantum_ival_ff;
      if (csr_we) begin
         case (csr_index)
            vsrs_pkg::REG_ENABLE: begin
               enable_in = csr_wdata[0];
            end
            vsrs_pkg::REG_FRAME_RATE: begin
               frame_rate_in = csr_wdata[vsrs_pkg::RATE_BITS-1:0];
            end
            vsrs_pkg::REG_FRAME_BYTES: begin
               frame_bytes_in = csr_wdata[vsrs_pkg::ALLOW_BITS-1:0];
            end
            vsrs_pkg::REG_QUANTUM_BYTES: begin
               quantum_bytes_in = csr_wdata[vsrs_pkg::ALLOW_BITS-1:0];
            end
            vsrs_pkg::REG_FRAME_INTERVAL: begin
               frame_ival_in = csr_wdata[vsrs_pkg::IVAL_BITS-1:0];
            end
            vsrs_pkg::REG_QUANTUM_INTERVAL: begin
               quantum_ival_in = csr_wdata[vsrs_pkg::IVAL_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff        <= 1'b0;
         frame_rate_ff    <= '0;
         frame_bytes_ff   <= '0;
         quantum_bytes_ff <= '0;
         frame_ival_ff    <= '0;
         quantum_ival_ff  <= '0;
      end else begin
         enable_ff        <= enable_in;
         frame_rate_ff    <= frame_rate_in;
         frame_bytes_ff   <= frame_bytes_in;
         quantum_bytes_ff <= quantum_bytes_in;
         frame_ival_ff    <= frame_ival_in;
         quantum_ival_ff  <= quantum_ival_in;
      end
   end

   // outputs, clear on any write to a defined register
   always_comb begin
      cfg.clear = csr_we && (csr_index inside
                  {[vsrs_pkg::REG_ENABLE:vsrs_pkg::REG_QUANTUM_INTERVAL]});
      cfg.enable           = enable_ff;
      cfg.frame_rate       = frame_rate_ff;
      cfg.frame_bytes      = frame_bytes_ff;
      cfg.quantum_bytes    = quantum_bytes_ff;
      cfg.frame_interval   = frame_ival_ff;
      cfg.quantum_interval = quantum_ival_ff;
   end

endmodule

[design/vsrs_alu.sv]
// shared bit-serial divide / saturating multiply unit
// depends on vsrs_pkg and video_stream_rate_shaper_assert.svh
`timescale 1ns / 1ps
`include "video_stream_rate_shaper_assert.svh"

module vsrs_alu #(
   parameter int W = 48
) (
   input  logic                              clock,
   input  logic                              reset,
   input  vsrs_pkg::alu_ctl_type             ctl,
   input  logic [vsrs_pkg::OPA_BITS-1:0]     opa,
   input  logic [W-1:0]                      opb,
   input  logic [W-1:0]                      lim,
   output vsrs_pkg::alu_sts_type             sts,
   output logic [vsrs_pkg::OPA_BITS-1:0]     quo,
   output logic [W-1:0]                      acc
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic                               div_ff, div_in;
   logic [vsrs_pkg::STEP_BITS-1:0]     cnt_ff, cnt_in;
   logic [vsrs_pkg::OPA_BITS-1:0]      opa_ff, opa_in;
   logic [W-1:0]                       opb_ff, opb_in;
   logic [W-1:0]                       lim_ff, lim_in;
   logic [W-1:0]                       acc_ff, acc_in;

   logic                               msb;
   logic [W-1:0]                       trial;
   logic                               div_ge;
   logic [W+1:0]                       mul_sum;
   logic                               mul_over;
   logic                               last_step;

   // one step: restoring divide or shift-add multiply, msb first
   always_comb begin
      msb       = opa_ff[vsrs_pkg::OPA_BITS-1];
      trial     = {acc_ff[W-2:0], msb};
      div_ge    = trial >= opb_ff;
      mul_sum   = {1'b0, acc_ff, 1'b0} + (msb ? {2'b00, opb_ff} : '0);
      mul_over  = mul_sum > {2'b00, lim_ff};
      last_step = cnt_ff == vsrs_pkg::STEP_BITS'(vsrs_pkg::OPA_BITS - 1);
   end

   // sequencing of the steps
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      lim_in  = lim_ff;
      acc_in  = acc_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         div_in  = ctl.is_div;
         cnt_in  = '0;
         opa_in  = opa;
         opb_in  = opb;
         lim_in  = lim;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (div_ff) begin
            if (div_ge) begin
               acc_in = trial - opb_ff;
               opa_in = {opa_ff[vsrs_pkg::OPA_BITS-2:0], 1'b1};
            end else begin
               acc_in = trial;
               opa_in = {opa_ff[vsrs_pkg::OPA_BITS-2:0], 1'b0};
            end
         end else begin
            opa_in = {opa_ff[vsrs_pkg::OPA_BITS-2:0], 1'b0};
            acc_in = mul_over ? lim_ff : mul_sum[W-1:0];
         end
         cnt_in = cnt_ff + vsrs_pkg::STEP_BITS'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         div_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         div_ff  <= div_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      lim_ff <= lim_in;
      acc_ff <= acc_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quo      = opa_ff;
   assign acc      = acc_ff;

   // checks
   `VSRS_ASSERT_NEXT(a_start_sets_busy, clock, reset, ctl.start, busy_ff)
   `VSRS_ASSERT(a_done_not_busy, clock, reset, !(done_ff && busy_ff))
   `VSRS_ASSERT_NEXT(a_last_step_done, clock, reset, busy_ff && last_step && !ctl.start, done_ff)

endmodule

[bench/tb_top.sv]
// testbench for video_stream_rate_shaper: directed and random packet and frame words
// checked against an in-bench model of the byte budget, frame pace and window state
// depends on vsrs_pkg and the rate shaper rtl
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned CYCLE_LIMIT   = 2000000;
   localparam int unsigned SETTLE_CYCLES = 200;
   localparam bit [63:0]   TIME_TOP      = 64'h0000_FFFF_FFFF_FFFF;
   localparam bit [63:0]   BYTE_TOP      = 64'h0000_FFFF_FFFF_FFFF;
   localparam bit [63:0]   FCOUNT_TOP    = 64'h0000_0000_0000_FFFF;
   localparam bit [63:0]   WINDOW_LEN_NS = 64'd1000000000;

   // one result word as the block should give it
   typedef struct {
      logic [1:0]                     status;
      logic [vsrs_pkg::NOW_BITS-1:0]  wait_ns;
      logic [vsrs_pkg::RATE_BITS-1:0] frames_left;
   } verdict_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic                               req_kind = vsrs_pkg::KIND_PACKET;
   logic [vsrs_pkg::NOW_BITS-1:0]      req_now_ns = '0;
   logic [vsrs_pkg::SIZE_BITS-1:0]     req_size = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [1:0]                         rsp_status;
   logic [vsrs_pkg::NOW_BITS-1:0]      rsp_wait_ns;
   logic [vsrs_pkg::RATE_BITS-1:0]     rsp_frames_left;
   logic                               csr_we = 1'b0;
   logic [vsrs_pkg::CSR_IDX_BITS-1:0]  csr_index = vsrs_pkg::REG_ENABLE;
   logic [vsrs_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   verdict_type budget_verdicts[$];
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_left = 0;
   bit          steady_flow = 1'b0;

   // register mirror
   bit          cfg_enable;
   bit [63:0]   cfg_frame_rate, cfg_frame_bytes, cfg_quantum_bytes;
   bit [63:0]   cfg_frame_ival, cfg_quantum_ival;

   // shaping state mirror
   bit          sh_started;
   bit [63:0]   sh_limit, sh_sent, sh_quantum;
   bit [63:0]   sh_frames_left, sh_ideal, sh_actual;
   bit [63:0]   sh_window_end, sh_next_frame, sh_next_refill;

   video_stream_rate_shaper DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_now_ns      (req_now_ns),
      .req_size        (req_size),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_wait_ns     (rsp_wait_ns),
      .rsp_frames_left (rsp_frames_left),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- model

   function automatic bit [63:0] add_clamped(bit [63:0] a, bit [63:0] b, bit [63:0] top);
      if (a > top || b > top - a) return top;
      return a + b;
   endfunction

   function automatic bit [63:0] mul_clamped(bit [63:0] a, bit [63:0] b, bit [63:0] top);
      if (a == 64'd0 || b == 64'd0) return 64'd0;
      if (a > top / b) return top;
      return a * b;
   endfunction

   function automatic bit [63:0] refill_wait(bit [63:0] now);
      return (sh_next_refill > now) ? sh_next_refill - now : 64'd0;
   endfunction

   function automatic void clear_shaping();
      sh_started     = 1'b0;
      sh_limit       = '0;
      sh_sent        = '0;
      sh_quantum     = '0;
      sh_frames_left = '0;
      sh_ideal       = '0;
      sh_actual      = '0;
      sh_window_end  = '0;
      sh_next_frame  = '0;
      sh_next_refill = '0;
   endfunction

   // budget and pace update for one word, returns the result it should give
   task automatic shape_word(input logic kind, input logic [vsrs_pkg::NOW_BITS-1:0] now_in,
                             input logic [vsrs_pkg::SIZE_BITS-1:0] size_in,
                             output verdict_type v);
      bit [63:0] now, n, due, want, need;
      now = 64'(now_in);
      v.status  = vsrs_pkg::STATUS_OK;
      v.wait_ns = '0;
      if (!cfg_enable) begin
         v.status = vsrs_pkg::STATUS_NA;
      end else if (kind == vsrs_pkg::KIND_PACKET) begin
         if (sh_started) begin
            // refills for every quantum interval that has fully passed
            if (sh_next_refill < now) begin
               n = 64'd1;
               if (cfg_quantum_ival != 64'd0) begin
                  n = (now - sh_next_refill - 64'd1) / cfg_quantum_ival + 64'd1;
                  sh_next_refill = add_clamped(sh_next_refill,
                     mul_clamped(n, cfg_quantum_ival, TIME_TOP), TIME_TOP);
               end
               sh_limit = add_clamped(sh_limit, mul_clamped(n, sh_quantum, BYTE_TOP),
                                      BYTE_TOP);
            end
         end else begin
            // first packet opens the window
            sh_started     = 1'b1;
            sh_limit       = cfg_quantum_bytes;
            sh_sent        = '0;
            sh_quantum     = cfg_quantum_bytes;
            sh_frames_left = cfg_frame_rate;
            sh_ideal       = 64'd1;
            sh_actual      = 64'd1;
            sh_window_end  = add_clamped(now, WINDOW_LEN_NS, TIME_TOP);
            sh_next_frame  = add_clamped(now, cfg_frame_ival, TIME_TOP);
            sh_next_refill = add_clamped(now, cfg_quantum_ival, TIME_TOP);
         end
         want = add_clamped(sh_sent, 64'(size_in), BYTE_TOP);
         if (sh_limit < want) begin
            v.status  = vsrs_pkg::STATUS_OVER;
            v.wait_ns = vsrs_pkg::NOW_BITS'(refill_wait(now));
         end else begin
            sh_sent = want;
         end
      end else if (sh_frames_left == 64'd0) begin
         // out of frames: close the window
         if (now < sh_window_end) begin
            v.status  = vsrs_pkg::STATUS_OVER;
            v.wait_ns = vsrs_pkg::NOW_BITS'(refill_wait(now));
         end
         clear_shaping();
      end else begin
         sh_actual = add_clamped(sh_actual, 64'd1, FCOUNT_TOP);
         if (sh_next_frame < now) begin
            n = sh_frames_left;
            if (cfg_frame_ival != 64'd0) begin
               due = (now - sh_next_frame - 64'd1) / cfg_frame_ival + 64'd1;
               if (due < n) n = due;
            end
            sh_frames_left = sh_frames_left - n;
            sh_ideal       = add_clamped(sh_ideal, n, FCOUNT_TOP);
            sh_next_frame  = add_clamped(sh_next_frame,
               mul_clamped(n, cfg_frame_ival, TIME_TOP), TIME_TOP);
         end
         need = mul_clamped(cfg_frame_bytes, sh_actual, BYTE_TOP);
         if (sh_sent < need) sh_sent = need;
         // behind the ideal pace doubles the quantum
         if (sh_ideal <= sh_actual) begin
            sh_quantum = cfg_quantum_bytes;
         end else begin
            sh_quantum = (sh_quantum > (BYTE_TOP >> 1)) ? BYTE_TOP : (sh_quantum << 1);
            v.status   = vsrs_pkg::STATUS_DELAY;
         end
      end
      v.frames_left = sh_frames_left[vsrs_pkg::RATE_BITS-1:0];
   endtask

   // ---------------------------------------------------------------- drivers

   // one request word; returns at the edge that takes it
   task automatic send_word(input logic kind, input logic [vsrs_pkg::NOW_BITS-1:0] now,
                            input logic [vsrs_pkg::SIZE_BITS-1:0] size);
      verdict_type v;
      int unsigned gap;
      gap = steady_flow ? 0 : $urandom_range(0, 10);
      shape_word(kind, now, size, v);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_kind   <= kind;
      req_now_ns <= now;
      req_size   <= size;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      budget_verdicts.push_back(v);
   endtask

   // stop sending and wait until every result word has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (budget_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // write all six registers back to back; each write also clears the state
   task automatic configure(input logic en, input logic [vsrs_pkg::RATE_BITS-1:0] rate,
                            input logic [vsrs_pkg::ALLOW_BITS-1:0] fbytes,
                            input logic [vsrs_pkg::ALLOW_BITS-1:0] qbytes,
                            input logic [vsrs_pkg::IVAL_BITS-1:0] fival,
                            input logic [vsrs_pkg::IVAL_BITS-1:0] qival);
      logic [vsrs_pkg::CSR_IDX_BITS-1:0]  slots[6];
      logic [vsrs_pkg::CSR_DATA_BITS-1:0] values[6];
      slots  = '{vsrs_pkg::REG_ENABLE, vsrs_pkg::REG_FRAME_RATE, vsrs_pkg::REG_FRAME_BYTES,
                 vsrs_pkg::REG_QUANTUM_BYTES, vsrs_pkg::REG_FRAME_INTERVAL,
                 vsrs_pkg::REG_QUANTUM_INTERVAL};
      values = '{vsrs_pkg::CSR_DATA_BITS'(en), vsrs_pkg::CSR_DATA_BITS'(rate),
                 vsrs_pkg::CSR_DATA_BITS'(fbytes), vsrs_pkg::CSR_DATA_BITS'(qbytes),
                 vsrs_pkg::CSR_DATA_BITS'(fival), vsrs_pkg::CSR_DATA_BITS'(qival)};
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= slots[i];
         csr_wdata <= values[i];
         @(posedge clock);
      end
      csr_we            <= 1'b0;
      cfg_enable        = en;
      cfg_frame_rate    = 64'(rate);
      cfg_frame_bytes   = 64'(fbytes);
      cfg_quantum_bytes = 64'(qbytes);
      cfg_frame_ival    = 64'(fival);
      cfg_quantum_ival  = 64'(qival);
      clear_shaping();
   endtask

   // ---------------------------------------------------------------- result check

   always @(posedge clock) begin : result_check
      verdict_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (budget_verdicts.size() == 0) begin
            $error("result word with nothing pending: status %0d", rsp_status);
            mismatches++;
         end else begin
            want = budget_verdicts.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_wait_ns !== want.wait_ns) begin
               $error("wait_ns: expected %0d, got %0d", want.wait_ns, rsp_wait_ns);
               mismatches++;
            end
            if (rsp_frames_left !== want.frames_left) begin
               $error("frames_left: expected %0d, got %0d", want.frames_left,
                      rsp_frames_left);
               mismatches++;
            end
         end
         hold_left = steady_flow ? 0 : $urandom_range(0, 10);
      end else if (rsp_valid === 1'b1 && hold_left != 0) begin
         hold_left--;
      end
      rsp_stall <= (hold_left != 0);
   end

   // ---------------------------------------------------------------- tests

   // disabled shaper answers every word as not available
   task automatic test_disabled();
      drain_results();
      configure(1'b0, 10'd5, 40'd100, 40'd1000, 30'd1000, 30'd500);
      send_word(vsrs_pkg::KIND_PACKET, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
      send_word(vsrs_pkg::KIND_FRAME, 48'd0, 16'd0);
   endtask

   // frame boundary before any packet, zero budget packets
   task automatic test_frame_before_start();
      drain_results();
      configure(1'b1, 10'd0, 40'd0, 40'd0, 30'd0, 30'd0);
      send_word(vsrs_pkg::KIND_FRAME, 48'd5, 16'd0);
      send_word(vsrs_pkg::KIND_PACKET, 48'd6, 16'd0);
      send_word(vsrs_pkg::KIND_PACKET, 48'd7, 16'd1);
   endtask

   // one window: refill, over budget, falling behind, close and reopen
   task automatic test_window_pacing();
      drain_results();
      configure(1'b1, 10'd3, 40'd100, 40'd1000, 30'd1000, 30'd500);
      send_word(vsrs_pkg::KIND_PACKET, 48'd0, 16'd600);
      send_word(vsrs_pkg::KIND_PACKET, 48'd100, 16'd600);
      send_word(vsrs_pkg::KIND_PACKET, 48'd600, 16'd600);
      send_word(vsrs_pkg::KIND_FRAME, 48'd700, 16'd0);
      send_word(vsrs_pkg::KIND_FRAME, 48'd3500, 16'd0);
      send_word(vsrs_pkg::KIND_FRAME, 48'd3600, 16'd0);
      send_word(vsrs_pkg::KIND_PACKET, 48'd3700, 16'd0);
   endtask

   // zero intervals: one quantum per late packet, a late frame takes all frames
   task automatic test_zero_intervals();
      drain_results();
      configure(1'b1, 10'd4, 40'd50, 40'd800, 30'd0, 30'd0);
      send_word(vsrs_pkg::KIND_PACKET, 48'd10, 16'd500);
      send_word(vsrs_pkg::KIND_PACKET, 48'd10, 16'd500);
      send_word(vsrs_pkg::KIND_PACKET, 48'd20, 16'd500);
      send_word(vsrs_pkg::KIND_FRAME, 48'd30, 16'd0);
      send_word(vsrs_pkg::KIND_FRAME, 48'd30, 16'd0);
   endtask

   // saturation of times and byte counters; frames behind the pace double the quantum
   task automatic test_saturation();
      logic [vsrs_pkg::NOW_BITS-1:0] base;
      base = 48'hFFFF_FFFF_FFFF - 48'd3000;
      drain_results();
      configure(1'b1, 10'h3FF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 30'd1, 30'd1000000000);
      send_word(vsrs_pkg::KIND_PACKET, base, 16'hFFFF);
      for (int i = 1; i <= 5; i++) begin
         send_word(vsrs_pkg::KIND_FRAME, base + 48'(i * 100), 16'd0);
      end
      send_word(vsrs_pkg::KIND_PACKET, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
      drain_results();
      configure(1'b1, 10'h3FF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 30'd1000000000, 30'd1);
      send_word(vsrs_pkg::KIND_PACKET, 48'd0, 16'd0);
      send_word(vsrs_pkg::KIND_PACKET, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
   endtask

   function automatic logic [vsrs_pkg::IVAL_BITS-1:0] pick_interval();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 30'd1000000000;
         2, 3:    return vsrs_pkg::IVAL_BITS'($urandom_range(1, 2000));
         4:       return vsrs_pkg::IVAL_BITS'($urandom_range(1, 1000000000));
         default: return vsrs_pkg::IVAL_BITS'($urandom_range(1000, 1000000));
      endcase
   endfunction

   // random phases: new settings, then a stream of packets with frame boundaries
   task automatic test_random_traffic(input int unsigned word_target);
      int unsigned                     counted, phase_len, scale;
      bit [63:0]                       clock_ns;
      logic                            en, kind;
      logic [vsrs_pkg::RATE_BITS-1:0]  rate;
      logic [vsrs_pkg::ALLOW_BITS-1:0] fbytes, qbytes;
      logic [vsrs_pkg::IVAL_BITS-1:0]  fival, qival;
      logic [vsrs_pkg::SIZE_BITS-1:0]  size;
      counted = 0;
      while (counted < word_target) begin
         drain_results();
         steady_flow = ($urandom_range(0, 3) == 0);
         en = ($urandom_range(0, 19) != 0);
         case ($urandom_range(0, 7))
            0:       rate = '0;
            1:       rate = '1;
            2:       rate = vsrs_pkg::RATE_BITS'($urandom);
            default: rate = vsrs_pkg::RATE_BITS'($urandom_range(1, 60));
         endcase
         case ($urandom_range(0, 7))
            0:       fbytes = '1;
            1:       fbytes = vsrs_pkg::ALLOW_BITS'({$urandom, $urandom});
            default: fbytes = vsrs_pkg::ALLOW_BITS'($urandom_range(0, 3000));
         endcase
         case ($urandom_range(0, 9))
            0:       qbytes = '1;
            1:       qbytes = vsrs_pkg::ALLOW_BITS'({$urandom, $urandom});
            2:       qbytes = '0;
            default: qbytes = vsrs_pkg::ALLOW_BITS'($urandom_range(0, 20000));
         endcase
         fival = pick_interval();
         qival = pick_interval();
         configure(en, rate, fbytes, qbytes, fival, qival);
         case ($urandom_range(0, 5))
            0:       clock_ns = '0;
            1:       clock_ns = 64'(48'({$urandom, $urandom}));
            2:       clock_ns = TIME_TOP - 64'($urandom_range(0, 2000000000));
            default: clock_ns = 64'($urandom);
         endcase
         phase_len = $urandom_range(20, 100);
         repeat (phase_len) begin
            scale = $urandom_range(0, 1) ? 32'(qival) : 32'(fival);
            if (scale == 0) scale = 1000;
            case ($urandom_range(0, 19))
               0, 1:    clock_ns = clock_ns;
               17:      clock_ns = clock_ns + 64'd1100000000 +
                                   64'($urandom_range(0, 100000000));
               18:      clock_ns = clock_ns + 64'($urandom_range(scale, 4 * scale));
               19:      clock_ns = clock_ns + (($urandom_range(0, 9) == 0) ?
                                               64'(48'({$urandom, $urandom})) : 64'd1);
               default: clock_ns = clock_ns + 64'($urandom_range(0, scale));
            endcase
            if (clock_ns > TIME_TOP) clock_ns = TIME_TOP;
            kind = ($urandom_range(0, 3) == 0) ? vsrs_pkg::KIND_FRAME : vsrs_pkg::KIND_PACKET;
            case ($urandom_range(0, 9))
               0:       size = '0;
               1:       size = '1;
               2:       size = vsrs_pkg::SIZE_BITS'($urandom);
               default: size = vsrs_pkg::SIZE_BITS'($urandom_range(40, 1500));
            endcase
            send_word(kind, clock_ns[vsrs_pkg::NOW_BITS-1:0], size);
            if (en) counted++;
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      clear_shaping();
      cfg_enable        = 1'b0;
      cfg_frame_rate    = '0;
      cfg_frame_bytes   = '0;
      cfg_quantum_bytes = '0;
      cfg_frame_ival    = '0;
      cfg_quantum_ival  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_disabled();
      test_frame_before_start();
      test_window_pacing();
      test_zero_intervals();
      test_saturation();
      test_random_traffic(1600);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
